/* rtl/core/pip_pkg.sv */
// pip_pkg: shared types and constants of the point-in-polygon block
// used by the channel interfaces and the top level; no dependencies

package pip_pkg;

    localparam int unsigned OP_W         = 2;
    localparam int unsigned INDEX_W      = 8;
    localparam int unsigned COORD_W      = 16;
    localparam int unsigned DIST_W       = 16;
    localparam int unsigned VCOUNT_W     = 9;
    localparam logic [DIST_W-1:0] DIST_MAX = 16'hFFFF;

    // operation codes of an input item
    localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
    localparam logic [OP_W-1:0] OP_INSIDE = 2'd1;
    localparam logic [OP_W-1:0] OP_DIST   = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_FIRST,
        S_EDGE,
        S_CHK,
        S_MUL2,
        S_PAR,
        S_DIVINIT,
        S_DIV,
        S_DIST,
        S_ADV,
        S_DONE
    } t_state;

endpackage

/* rtl/core/pip_if.sv */
// pip_if: valid/ready channel interfaces for items, results and configuration
// depends on pip_pkg for field widths

interface pip_in_if import pip_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic        [OP_W-1:0]     op;
    logic        [INDEX_W-1:0]  vertex_index;
    logic signed [COORD_W-1:0]  coord_x;
    logic signed [COORD_W-1:0]  coord_y;

    modport source (output valid, op, vertex_index, coord_x, coord_y, input ready);
    modport sink   (input valid, op, vertex_index, coord_x, coord_y, output ready);
endinterface

interface pip_out_if import pip_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                is_inside;
    logic [DIST_W-1:0]   distance;
    logic                no_edge;
    logic                load_ack;

    modport source (output valid, is_inside, distance, no_edge, load_ack, input ready);
    modport sink   (input valid, is_inside, distance, no_edge, load_ack, output ready);
endinterface

interface pip_cfg_if import pip_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [VCOUNT_W-1:0]   data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

/* rtl/core/point_in_polygon_and_hdistance.sv */
// point_in_polygon_and_hdistance: vertex store, crossing-parity inside test and
// horizontal edge distance on one shared multiplier and a bit-serial divider
// depends on pip_pkg and the channel interfaces in pip_if.sv
// flow: a load or unused op goes from idle to the done state and the output register;
// a query walks the edges, a spanning edge taking the inside-test multiply or, when
// sloped, the bit-serial divide; one item at a time, held in done while the output stalls
// reset: synchronous active low, clears sequencer, vertex count and output valid

module point_in_polygon_and_hdistance
    import pip_pkg::*;
#(
    parameter int MAX_VERTICES = 256,
    parameter int COORD_BITS   = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pip_in_if.sink    i_in,
    pip_cfg_if.sink   i_cfg,
    pip_out_if.source o_out
);

    localparam int CW    = (COORD_BITS < 16) ? COORD_BITS : 16;
    localparam int AW    = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CNTW  = $clog2(MAX_VERTICES + 1);
    localparam int NW    = (CNTW > VCOUNT_W) ? CNTW : VCOUNT_W;
    localparam int MW    = CW + 2;
    localparam int PW    = 2 * MW;
    localparam int QW    = CW + 2;
    localparam int SW    = CW + 3;
    localparam int DCW   = $clog2(PW + 1);

    // vertex store
    logic [2*CW-1:0] mem [MAX_VERTICES];
    logic [2*CW-1:0] r_rdata;
    logic            rd_en;
    logic [AW-1:0]   rd_addr;
    logic            wr_en;

    t_state r_state, n_state;

    logic [VCOUNT_W-1:0]   r_vcount;
    logic [OP_W-1:0]       r_op;
    logic [CNTW-1:0]       r_n;
    logic [CNTW-1:0]       r_i;
    logic signed [CW-1:0]  r_xp, r_yp, r_ax, r_ay, r_bx, r_by;
    logic                  r_odd, r_found;
    logic [DIST_W-1:0]     r_best;
    logic signed [PW-1:0]  r_prod, r_prod2;
    logic [PW-1:0]         r_quo;
    logic [CW+1:0]         r_rem;
    logic [CW:0]           r_den;
    logic                  r_neg;
    logic [DCW-1:0]        r_dcnt;

    logic                  r_out_valid, r_out_inside, r_out_no_edge, r_out_ack;
    logic [DIST_W-1:0]     r_out_dist;

    logic                  in_fire;
    logic [CNTW-1:0]       nsat;
    logic signed [CW-1:0]  in_x, in_y, rd_x, rd_y;
    logic signed [MW-1:0]  mul_a, mul_b;
    logic signed [PW-1:0]  mul_p;
    logic                  span_in, span_dist, level;
    logic signed [PW+1:0]  dd;
    logic [CW+1:0]         rem_sh;
    logic                  ge;
    logic signed [QW-1:0]  q_s;
    logic signed [SW-1:0]  d_raw, d1_raw, d2_raw;
    logic [SW-1:0]         d_abs, d1_abs, d2_abs, dl_abs, d_new;
    logic signed [CW:0]    den_s;
    logic                  upd_best;
    logic                  edges_done;
    logic                  out_free;

    // handshake and input decode
    assign in_fire     = i_in.valid && i_in.ready;
    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign in_x        = i_in.coord_x[CW-1:0];
    assign in_y        = i_in.coord_y[CW-1:0];
    assign rd_x        = r_rdata[2*CW-1:CW];
    assign rd_y        = r_rdata[CW-1:0];
    assign nsat = (NW'(r_vcount) > NW'(MAX_VERTICES)) ? CNTW'(MAX_VERTICES)
                                                       : CNTW'(r_vcount);
    assign wr_en = in_fire && (i_in.op == OP_LOAD)
                   && (32'(i_in.vertex_index) < 32'(MAX_VERTICES));
    assign out_free   = !r_out_valid || o_out.ready;
    assign edges_done = (CNTW'(r_i + CNTW'(2)) >= r_n);

    // edge classification
    assign span_in   = (r_ay > r_yp) != (r_by > r_yp);
    assign span_dist = !(((r_ay > r_yp) && (r_by > r_yp)) || ((r_ay < r_yp) && (r_by < r_yp)));
    assign level     = (r_ay == r_by);

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (r_state == S_CHK && r_op == OP_INSIDE) begin
            mul_a = MW'(r_bx) - MW'(r_ax);
            mul_b = (MW'(r_yp) - MW'(r_ay)) * MW'(2) + MW'(1);
        end else if (r_state == S_CHK) begin
            mul_a = MW'(r_yp) - MW'(r_ay);
            mul_b = MW'(r_bx) - MW'(r_ax);
        end else if (r_state == S_MUL2) begin
            mul_a = MW'(r_xp) - MW'(r_ax);
            mul_b = MW'(r_by) - MW'(r_ay);
        end
    end
    assign mul_p = PW'(mul_a) * PW'(mul_b);

    // crossing sign
    assign dd = (PW+2)'(r_prod) - ((PW+2)'(r_prod2) <<< 1);

    // divider step
    assign rem_sh = {r_rem[CW:0], r_quo[PW-1]};
    assign ge     = rem_sh >= {1'b0, r_den};
    assign den_s  = (CW+1)'(r_by) - (CW+1)'(r_ay);

    // distance candidates
    assign q_s    = r_neg ? -$signed(QW'(r_quo)) : $signed(QW'(r_quo));
    assign d_raw  = SW'(r_ax) - SW'(r_xp) + SW'(q_s);
    assign d1_raw = SW'(r_bx) - SW'(r_xp);
    assign d2_raw = SW'(r_ax) - SW'(r_xp);
    assign d_abs  = d_raw[SW-1]  ? SW'(-d_raw)  : SW'(d_raw);
    assign d1_abs = d1_raw[SW-1] ? SW'(-d1_raw) : SW'(d1_raw);
    assign d2_abs = d2_raw[SW-1] ? SW'(-d2_raw) : SW'(d2_raw);
    assign dl_abs = (d1_abs < d2_abs) ? d1_abs : d2_abs;
    assign d_new  = (r_state == S_DIST) ? d_abs : dl_abs;
    assign upd_best = 32'(d_new) < 32'(r_best);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if ((i_in.op == OP_INSIDE || i_in.op == OP_DIST) && nsat >= CNTW'(2))
                        n_state = S_FIRST;
                    else
                        n_state = S_DONE;
                end
            end
            S_FIRST: n_state = S_EDGE;
            S_EDGE:  n_state = S_CHK;
            S_CHK: begin
                if (r_op == OP_INSIDE)
                    n_state = span_in ? S_MUL2 : S_ADV;
                else if (!span_dist || level)
                    n_state = S_ADV;
                else
                    n_state = S_DIVINIT;
            end
            S_MUL2:    n_state = S_PAR;
            S_PAR:     n_state = S_ADV;
            S_DIVINIT: n_state = S_DIV;
            S_DIV:     n_state = (r_dcnt == DCW'(1)) ? S_DIST : S_DIV;
            S_DIST:    n_state = S_ADV;
            S_ADV:     n_state = edges_done ? S_DONE : S_EDGE;
            S_DONE:    n_state = out_free ? S_IDLE : S_DONE;
            default:   n_state = S_IDLE;
        endcase
    end

    // store read control
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = '0;
        case (r_state)
            S_IDLE: begin
                rd_en = in_fire;
            end
            S_FIRST: begin
                rd_en   = 1'b1;
                rd_addr = AW'(1);
            end
            S_ADV: begin
                rd_en   = !edges_done;
                rd_addr = AW'(r_i + CNTW'(2));
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    // vertex store write and registered read
    always_ff @(posedge i_clk) begin
        if (wr_en)
            mem[AW'(i_in.vertex_index)] <= {in_x, in_y};
        if (rd_en)
            r_rdata <= mem[rd_addr];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_vcount    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid && i_cfg.ready)
                r_vcount <= i_cfg.data;
            if (r_state == S_DONE && out_free)
                r_out_valid <= 1'b1;
            else if (o_out.ready)
                r_out_valid <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    r_op    <= i_in.op;
                    r_xp    <= in_x;
                    r_yp    <= in_y;
                    r_n     <= nsat;
                    r_i     <= '0;
                    r_odd   <= 1'b0;
                    r_found <= 1'b0;
                    r_best  <= DIST_MAX;
                end
            end
            S_FIRST: begin
                r_ax <= rd_x;
                r_ay <= rd_y;
            end
            S_EDGE: begin
                r_bx <= rd_x;
                r_by <= rd_y;
            end
            S_CHK: begin
                r_prod <= mul_p;
                if (r_op == OP_DIST && span_dist) begin
                    r_found <= 1'b1;
                    if (level && upd_best)
                        r_best <= DIST_W'(d_new);
                end
            end
            S_MUL2: begin
                r_prod2 <= mul_p;
            end
            S_PAR: begin
                if ((dd > 0 && r_by > r_ay) || (dd < 0 && r_by < r_ay))
                    r_odd <= !r_odd;
            end
            S_DIVINIT: begin
                r_quo  <= r_prod[PW-1] ? PW'(-r_prod) : PW'(r_prod);
                r_den  <= den_s[CW] ? (CW+1)'(-den_s) : (CW+1)'(den_s);
                r_neg  <= r_prod[PW-1] != den_s[CW];
                r_rem  <= '0;
                r_dcnt <= DCW'(PW);
            end
            S_DIV: begin
                r_rem  <= ge ? (CW+2)'(rem_sh - {1'b0, r_den}) : rem_sh;
                r_quo  <= {r_quo[PW-2:0], ge};
                r_dcnt <= r_dcnt - DCW'(1);
            end
            S_DIST: begin
                if (upd_best)
                    r_best <= DIST_W'(d_new);
            end
            S_ADV: begin
                r_ax <= r_bx;
                r_ay <= r_by;
                r_i  <= r_i + CNTW'(1);
            end
            S_DONE: begin
                if (out_free) begin
                    r_out_ack     <= (r_op == OP_LOAD);
                    r_out_inside  <= (r_op == OP_INSIDE) && r_odd;
                    r_out_no_edge <= (r_op == OP_DIST) && !r_found;
                    r_out_dist    <= (r_op == OP_DIST) ? r_best : '0;
                end
            end
            default: begin
                r_i <= r_i;
            end
        endcase
    end

    // result channel
    assign o_out.valid     = r_out_valid;
    assign o_out.is_inside = r_out_inside;
    assign o_out.distance  = r_out_dist;
    assign o_out.no_edge   = r_out_no_edge;
    assign o_out.load_ack  = r_out_ack;

`ifndef ASSERT_OFF
    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> $countones({o_out.is_inside, o_out.no_edge, o_out.load_ack}) <= 1)
        else $error("more than one result flag set");
    a_no_edge_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.no_edge) |-> (o_out.distance == DIST_MAX))
        else $error("no spanning edge but distance not saturated");
    a_load_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_in.op == OP_LOAD) |=> (r_state == S_DONE))
        else $error("load item did not finish at once");
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < {1'b0, r_den}))
        else $error("divider remainder out of range");
`endif

endmodule
